// ===== rtl/pwfe_pkg.sv =====
package pwfe_pkg;

	// command opcodes, also used as the run kind inside the block
	localparam logic [1:0] OP_SYNC  = 2'd0;
	localparam logic [1:0] OP_DATA  = 2'd1;
	localparam logic [1:0] OP_TRAIL = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_SYNC_REPEATS   = 2'd0;
	localparam logic [1:0] CFG_TRAILER_PULSES = 2'd1;

	// reset values of the configuration registers
	localparam logic [3:0] SYNC_REPEATS_RST   = 4'd10;
	localparam logic [3:0] TRAILER_PULSES_RST = 4'd5;

	// symbol widths in ticks
	localparam logic [1:0] WIDTH_SHORT = 2'd1;
	localparam logic [1:0] WIDTH_MID   = 2'd2;
	localparam logic [1:0] WIDTH_LONG  = 2'd3;

	// one classified command waiting for the sequencer
	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] count;
		logic [7:0] data_byte;
	} pwfe_cmd_t;

endpackage

// ===== rtl/pwfe_queue.sv =====
module pwfe_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  pwfe_pkg::pwfe_cmd_t push_cmd,
	output logic               full,
	input  logic               pop,
	output pwfe_pkg::pwfe_cmd_t pop_cmd,
	output logic               nempty
);
	import pwfe_pkg::*;

	pwfe_cmd_t  slot_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] fill_q;

	assign full    = (fill_q == 2'd2);
	assign nempty  = (fill_q != 2'd0);
	assign pop_cmd = slot_q[rptr_q];

	// store pushed command
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_cmd;
		end
	end

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

// ===== rtl/pwfe_front.sv =====
module pwfe_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [3:0]         cfg_data,
	input  logic               s_valid,
	output logic               s_ready,
	input  logic [1:0]         s_opcode,
	input  logic [7:0]         s_data_byte,
	input  logic               q_full,
	output logic               q_push,
	output pwfe_pkg::pwfe_cmd_t q_cmd
);
	import pwfe_pkg::*;

	logic [3:0] sync_repeats_q;
	logic [3:0] trailer_pulses_q;
	logic       keep;

	assign cfg_ready = 1'b1;
	assign s_ready   = !q_full;

	// configuration registers, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_repeats_q   <= SYNC_REPEATS_RST;
			trailer_pulses_q <= TRAILER_PULSES_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SYNC_REPEATS:   sync_repeats_q   <= cfg_data;
				CFG_TRAILER_PULSES: trailer_pulses_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// classify: drop unknown opcodes and empty trailers, attach run length
	always_comb begin
		keep          = 1'b0;
		q_cmd.kind    = s_opcode;
		q_cmd.count   = 4'd0;
		q_cmd.data_byte = s_data_byte;
		unique case (s_opcode)
			OP_SYNC: begin
				keep        = 1'b1;
				q_cmd.count = sync_repeats_q;
			end
			OP_DATA: begin
				keep = 1'b1;
			end
			OP_TRAIL: begin
				keep        = (trailer_pulses_q != 4'd0);
				q_cmd.count = trailer_pulses_q;
			end
			default: keep = 1'b0;
		endcase
	end

	assign q_push = s_valid && s_ready && keep;

endmodule

// ===== rtl/pwfe_back.sv =====
module pwfe_back #(
	parameter int BITS_PER_BYTE = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_nempty,
	input  pwfe_pkg::pwfe_cmd_t q_cmd,
	output logic               q_pop,
	output logic               m_valid,
	input  logic               m_ready,
	output logic [1:0]         m_width,
	output logic               m_last
);
	import pwfe_pkg::*;

	localparam int CW = $clog2(2 * BITS_PER_BYTE + 1);
	localparam int XW = (BITS_PER_BYTE > 8) ? BITS_PER_BYTE : 8;
	localparam logic [CW-1:0] NBITS = CW'(BITS_PER_BYTE);
	localparam logic [CW-1:0] NEND  = CW'(2 * BITS_PER_BYTE);

	logic                     busy_q;
	logic [1:0]               kind_q;
	logic [3:0]               rep_q;
	logic [1:0]               sub_q;
	logic [CW-1:0]            idx_q;
	logic [BITS_PER_BYTE-1:0] sh_q;
	logic                     ovalid_q;
	logic [1:0]               owidth_q;
	logic                     olast_q;

	logic                     adv;
	logic [1:0]               sym_width;
	logic                     sym_last;
	logic [XW-1:0]            data_ext;

	assign m_valid  = ovalid_q;
	assign m_width  = owidth_q;
	assign m_last   = olast_q;

	assign adv      = busy_q && (!ovalid_q || m_ready);
	assign q_pop    = q_nempty && (!busy_q || (adv && sym_last));
	assign data_ext = XW'(q_cmd.data_byte);

	// pick the current symbol of the run
	always_comb begin
		sym_width = WIDTH_LONG;
		sym_last  = 1'b0;
		unique case (kind_q)
			OP_SYNC: begin
				if (rep_q == 4'd0) begin
					sym_last = 1'b1;
				end else begin
					sym_width = sub_q + 2'd1;
				end
			end
			OP_DATA: begin
				if (idx_q == NEND) begin
					sym_last = 1'b1;
				end else if (idx_q < NBITS) begin
					sym_width = sh_q[0] ? WIDTH_MID : WIDTH_SHORT;
				end else begin
					sym_width = sh_q[0] ? WIDTH_SHORT : WIDTH_MID;
				end
			end
			OP_TRAIL: begin
				sym_last = (rep_q == 4'd1);
			end
			default: sym_last = 1'b1;
		endcase
	end

	// sequencer: load a command, step through its run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			kind_q <= OP_SYNC;
			rep_q  <= 4'd0;
			sub_q  <= 2'd0;
			idx_q  <= '0;
		end else if (q_pop) begin
			busy_q <= 1'b1;
			kind_q <= q_cmd.kind;
			rep_q  <= q_cmd.count;
			sub_q  <= 2'd0;
			idx_q  <= '0;
		end else if (adv) begin
			if (sym_last) begin
				busy_q <= 1'b0;
			end
			idx_q <= idx_q + CW'(1);
			if (kind_q == OP_SYNC) begin
				if (sub_q == 2'd2) begin
					sub_q <= 2'd0;
					rep_q <= rep_q - 4'd1;
				end else begin
					sub_q <= sub_q + 2'd1;
				end
			end else if (kind_q == OP_TRAIL) begin
				rep_q <= rep_q - 4'd1;
			end
		end
	end

	// bit shifter rotates so the inverted pass sees the byte again
	always_ff @(posedge clk) begin
		if (q_pop) begin
			sh_q <= data_ext[BITS_PER_BYTE-1:0];
		end else if (adv) begin
			sh_q <= (sh_q >> 1) | (BITS_PER_BYTE'(sh_q[0]) << (BITS_PER_BYTE - 1));
		end
	end

	// output register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (adv) begin
			ovalid_q <= 1'b1;
		end else if (m_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			owidth_q <= sym_width;
			olast_q  <= sym_last;
		end
	end

endmodule

// ===== rtl/pulse_width_frame_encoder_top.sv =====
// Pulse-width frame encoder.
// Command beats enter on s_axis (tuser = opcode: sync, data frame, trailer;
// tdata = data byte). Each command becomes a run of symbol beats on m_axis:
// tdata holds the symbol width (1..3 ticks), tlast marks the final symbol.
// Sync gives sync_repeats triplets 1,2,3 then a 3; a data frame gives the
// byte bits LSB first (2 = one, 1 = zero), the inverted bits, then a 3;
// a trailer gives trailer_pulses symbols of 3. Opcode 3 and empty trailers
// produce nothing. Registers are set through the cfg channel (index 0
// sync_repeats, 1 trailer_pulses); the user must set them only while
// the block is idle, the block does not enforce this. The back end emits
// one symbol per cycle unless m_axis stalls; a run is 2*BITS_PER_BYTE+1
// symbols for a data frame, 3*N+1 for sync, N for a trailer, and a queued
// run follows without a gap. On an idle block a command passes the queue
// and the sequencer before the output register raises m_axis_tvalid. A
// two-entry command queue accepts new commands while a run goes out.
// A stalled m_axis holds the output register and freezes the sequencer;
// s_axis stalls once the queue is full. Reset empties the queue and the
// output register and restores sync_repeats 10 and trailer_pulses 5.
module pulse_width_frame_encoder_top #(
	parameter int BITS_PER_BYTE = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [3:0] cfg_data,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] data_byte
	input  logic [1:0] s_axis_tuser,  // [1:0] opcode
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [1:0] pulse_width, [7:2] zero
	output logic       m_axis_tlast
);
	import pwfe_pkg::*;

	pwfe_cmd_t  push_cmd;
	pwfe_cmd_t  pop_cmd;
	logic       q_push;
	logic       q_pop;
	logic       q_full;
	logic       q_nempty;
	logic [1:0] width;

	pwfe_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.s_valid     (s_axis_tvalid),
		.s_ready     (s_axis_tready),
		.s_opcode    (s_axis_tuser),
		.s_data_byte (s_axis_tdata),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_cmd       (push_cmd)
	);

	pwfe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.pop_cmd  (pop_cmd),
		.nempty   (q_nempty)
	);

	pwfe_back #(
		.BITS_PER_BYTE (BITS_PER_BYTE)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_nempty (q_nempty),
		.q_cmd    (pop_cmd),
		.q_pop    (q_pop),
		.m_valid  (m_axis_tvalid),
		.m_ready  (m_axis_tready),
		.m_width  (width),
		.m_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {6'd0, width};

endmodule

// ===== tb/tb_pulse_width_frame_encoder_top.sv =====
module tb_pulse_width_frame_encoder_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pwfe_pkg::*;

	localparam int BPB             = 8;
	localparam int DRAIN_CYCLES    = 20;
	localparam int CYCLE_LIMIT     = 2_000_000;
	localparam int RANDOM_PHASES   = 6;
	localparam int ITEMS_PER_PHASE = 55;

	// opcode and register indexes the block must ignore
	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam logic [1:0] CFG_UNUSED2 = 2'd2;
	localparam logic [1:0] CFG_UNUSED3 = 2'd3;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] data_byte;
	} command_t;

	typedef struct packed {
		logic [1:0] index;
		logic [3:0] value;
	} reg_write_t;

	typedef struct packed {
		logic [1:0] width;
		logic       last;
	} symbol_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [3:0] cfg_data = '0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = '0;   // [7:0] data_byte
	logic [1:0] s_axis_tuser = '0;   // [1:0] opcode
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;        // [1:0] pulse_width, [7:2] zero
	logic       m_axis_tlast;

	pulse_width_frame_encoder_top #(
		.BITS_PER_BYTE(BPB)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	command_t   cmd_q[$];
	reg_write_t reg_q[$];
	symbol_t    pending_symbols[$];

	// shadow copy of the block's registers
	logic [3:0] sync_n  = SYNC_REPEATS_RST;
	logic [3:0] trail_n = TRAILER_PULSES_RST;

	int errors = 0;
	int symbols_checked = 0;
	int settings_used = 1;
	int cmds_per_op[4] = '{0, 0, 0, 0};
	int cycle_count = 0;
	int in_gap = 0;
	int out_hold = 0;
	bit no_idle_in = 1'b0;
	bit no_idle_out = 1'b0;
	command_t next_cmd;
	symbol_t  want;

	initial begin
		forever #5 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int next_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(15, 30);
	endfunction

	function automatic void add_symbol(input logic [1:0] w);
		symbol_t s;
		s.width = w;
		s.last  = 1'b0;
		pending_symbols.push_back(s);
	endfunction

	// append the symbol run one command stands for
	function automatic void encode_command(input logic [1:0] op, input logic [7:0] din);
		int first;
		logic [31:0] wide;
		first = pending_symbols.size();
		wide  = {24'd0, din};
		case (op)
			OP_SYNC: begin
				for (int i = 0; i < sync_n; i++) begin
					add_symbol(WIDTH_SHORT);
					add_symbol(WIDTH_MID);
					add_symbol(WIDTH_LONG);
				end
				add_symbol(WIDTH_LONG);
			end
			OP_DATA: begin
				for (int i = 0; i < BPB; i++)
					add_symbol(wide[i] ? WIDTH_MID : WIDTH_SHORT);
				for (int i = 0; i < BPB; i++)
					add_symbol(wide[i] ? WIDTH_SHORT : WIDTH_MID);
				add_symbol(WIDTH_LONG);
			end
			OP_TRAIL: begin
				for (int i = 0; i < trail_n; i++)
					add_symbol(WIDTH_LONG);
			end
			default: ;
		endcase
		if (pending_symbols.size() > first)
			pending_symbols[$].last = 1'b1;
	endfunction

	// command driver: hold the beat until taken, then pull the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			in_gap = 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (in_gap != 0) begin
				in_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (cmd_q.size() != 0) begin
				next_cmd = cmd_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tuser  <= next_cmd.opcode;
				s_axis_tdata  <= next_cmd.data_byte;
				in_gap = no_idle_in ? 0 : next_gap();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// register write driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
		end else if (!cfg_valid || cfg_ready) begin
			if (reg_q.size() != 0) begin
				cfg_valid <= 1'b1;
				cfg_index <= reg_q[0].index;
				cfg_data  <= reg_q[0].value;
				void'(reg_q.pop_front());
			end else begin
				cfg_valid <= 1'b0;
			end
		end
	end

	// output back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			out_hold = 0;
		end else if (out_hold != 0) begin
			out_hold--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			out_hold = no_idle_out ? 0 : next_gap();
		end
	end

	// track register writes, predict on command beats, check symbol beats
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SYNC_REPEATS:   sync_n  = cfg_data;
					CFG_TRAILER_PULSES: trail_n = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				cmds_per_op[s_axis_tuser]++;
				encode_command(s_axis_tuser, s_axis_tdata);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_symbols.size() == 0) begin
					$display("%0t: symbol beat with none pending: expected none, actual tdata %h tlast %b",
						$time, m_axis_tdata, m_axis_tlast);
					errors++;
				end else begin
					want = pending_symbols.pop_front();
					symbols_checked++;
					if (m_axis_tdata !== {6'd0, want.width}) begin
						$display("%0t: pulse width: expected tdata %h, actual %h",
							$time, {6'd0, want.width}, m_axis_tdata);
						errors++;
					end
					if (m_axis_tlast !== want.last) begin
						$display("%0t: tlast: expected %b, actual %b",
							$time, want.last, m_axis_tlast);
						errors++;
					end
				end
			end
		end
	end

	// run watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d symbols still pending",
				cycle_count, pending_symbols.size());
			$display("pulse_width_frame_encoder_top: mismatch");
			$finish;
		end
	end

	task automatic queue_cmd(input logic [1:0] op, input logic [7:0] din);
		command_t c;
		c.opcode    = op;
		c.data_byte = din;
		cmd_q.push_back(c);
	endtask

	// wait until everything is out, then let commands without output finish
	task automatic settle();
		do
			@(negedge clk);
		while (cmd_q.size() != 0 || reg_q.size() != 0 || s_axis_tvalid || cfg_valid ||
			pending_symbols.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// write both registers on an idle block, plus the unmapped indexes
	task automatic apply_setting(input logic [3:0] sync_val, input logic [3:0] trail_val);
		settle();
		reg_q.push_back('{index: CFG_SYNC_REPEATS, value: sync_val});
		reg_q.push_back('{index: CFG_TRAILER_PULSES, value: trail_val});
		reg_q.push_back('{index: CFG_UNUSED2, value: 4'($urandom_range(0, 15))});
		reg_q.push_back('{index: CFG_UNUSED3, value: 4'($urandom_range(0, 15))});
		settle();
		settings_used++;
	endtask

	function automatic logic [3:0] pick_reg_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15) return 4'd0;
		if (r < 30) return 4'd15;
		if (r < 40) return 4'd1;
		return 4'($urandom_range(0, 15));
	endfunction

	initial begin
		int r;
		int n;
		logic [1:0] op;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset register values: every opcode, byte extremes and patterns
		queue_cmd(OP_SYNC, 8'h00);
		queue_cmd(OP_DATA, 8'h00);
		queue_cmd(OP_DATA, 8'hFF);
		queue_cmd(OP_DATA, 8'hA5);
		queue_cmd(OP_DATA, 8'h5A);
		queue_cmd(OP_DATA, 8'h01);
		queue_cmd(OP_DATA, 8'h80);
		queue_cmd(OP_TRAIL, 8'hFF);
		queue_cmd(OP_UNUSED, 8'hFF);
		queue_cmd(OP_DATA, 8'h3C);

		// smallest nonzero counts
		apply_setting(4'd1, 4'd1);
		queue_cmd(OP_SYNC, 8'h55);
		queue_cmd(OP_DATA, 8'h96);
		queue_cmd(OP_TRAIL, 8'h00);

		// largest counts, longest sync run
		apply_setting(4'd15, 4'd15);
		queue_cmd(OP_SYNC, 8'hFF);
		queue_cmd(OP_DATA, 8'h69);
		queue_cmd(OP_TRAIL, 8'hAA);
		queue_cmd(OP_UNUSED, 8'h00);

		// zero counts: bare sync closer, empty trailer
		apply_setting(4'd0, 4'd0);
		queue_cmd(OP_SYNC, 8'h0F);
		queue_cmd(OP_TRAIL, 8'hF0);
		queue_cmd(OP_DATA, 8'hC3);

		// random phases, some without idling on one or both sides
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			apply_setting(pick_reg_value(), pick_reg_value());
			no_idle_in  = (ph == 1 || ph == 3);
			no_idle_out = (ph == 2 || ph == 3);
			n = 0;
			while (n < ITEMS_PER_PHASE) begin
				r = $urandom_range(0, 99);
				if (r < 5) begin
					queue_cmd(OP_UNUSED, 8'($urandom_range(0, 255)));
				end else begin
					if (r < 25)
						op = OP_SYNC;
					else if (r < 80)
						op = OP_DATA;
					else
						op = OP_TRAIL;
					queue_cmd(op, 8'($urandom_range(0, 255)));
					n++;
				end
			end
		end

		settle();
		$display("covered %0d commands (sync %0d, data %0d, trailer %0d, unused %0d)",
			cmds_per_op[0] + cmds_per_op[1] + cmds_per_op[2] + cmds_per_op[3],
			cmds_per_op[0], cmds_per_op[1], cmds_per_op[2], cmds_per_op[3]);
		$display("checked %0d symbol beats over %0d register settings, %0d errors",
			symbols_checked, settings_used, errors);
		if (errors == 0)
			$display("pulse_width_frame_encoder_top: match");
		else
			$display("pulse_width_frame_encoder_top: mismatch");
		$finish;
	end

endmodule
